[src/pts_pkg.sv]
package pts_pkg;

  localparam int unsigned PID_W    = 13;
  localparam int unsigned KIND_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_W    = 5;

  typedef enum logic {
    FUNC_ADD    = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [KIND_W-1:0] kind;
  } entry_t;

  // same: exact pair match (add); hit: match under wildcards (remove)
  typedef struct packed {
    logic same;
    logic hit;
  } match_t;

endpackage

[src/pts_match.sv]
module pts_match (
  input  pts_pkg::entry_t             entry_i,
  input  logic [pts_pkg::PID_W-1:0]   pid_i,
  input  logic                        pid_any_i,
  input  logic [pts_pkg::KIND_W-1:0]  kind_i,
  input  logic                        kind_any_i,
  output pts_pkg::match_t             match_o
);
  import pts_pkg::*;

  logic pid_eq;
  logic kind_eq;

  assign pid_eq        = (entry_i.pid == pid_i);
  assign kind_eq       = (entry_i.kind == kind_i);
  assign match_o.same  = pid_eq && kind_eq;
  assign match_o.hit   = (pid_any_i || pid_eq) && (kind_any_i || kind_eq);

endmodule

[src/pid_type_set_table.sv]
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o | func_i pid_i pid_any_i kind_i kind_any_i
// out     | output    | out_valid_o/out_ready_i | status_o entries_now_o removed_o
//
// One operation at a time. Add and remove walk the stored entries through the
// single-read-port table, one entry per cycle. Remove on an empty table and
// full-wildcard remove skip the table walk. Reset clears the entry count,
// state and output valid only; table contents need no clearing.
// A finished result waits in the output register; the next beat is taken
// meanwhile and stalls only at completion if the old result is still held.
module pid_type_set_table #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [pts_pkg::PID_W-1:0]      pid_i,
  input  logic                           pid_any_i,
  input  logic [pts_pkg::KIND_W-1:0]     kind_i,
  input  logic                           kind_any_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pts_pkg::STATUS_W-1:0]   status_o,
  output logic [pts_pkg::OUT_W-1:0]      entries_now_o,
  output logic [pts_pkg::OUT_W-1:0]      removed_o
);
  import pts_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW = $clog2(MAX_ENTRIES);

  state_e state_q, state_d;

  // held item
  func_e             func_q;
  logic [PID_W-1:0]  pid_q;
  logic              pid_any_q;
  logic [KIND_W-1:0] kind_q;
  logic              kind_any_q;
  logic              item_ld;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] keep_q, keep_d;
  logic [CW-1:0] rm_q, rm_d;
  logic          found_q, found_d;
  logic          chk_q, chk_d;
  status_e       status_q, status_d;

  // table
  entry_t        store_q [MAX_ENTRIES];
  entry_t        rdata_q;
  logic          mem_re;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;

  match_t        match;
  entry_t        item_word;
  logic          more;
  logic          quick;
  logic          out_free;
  logic          out_ld;
  logic          out_valid_q;
  logic [CW+OUT_W-1:0] cnt_ext;
  logic [CW+OUT_W-1:0] rm_ext;

  assign item_word.pid  = pid_q;
  assign item_word.kind = kind_q;
  assign more     = (rd_idx_q < cnt_q);
  assign quick    = (func_i == FUNC_REMOVE) &&
                    ((cnt_q == '0) || (pid_any_i && kind_any_i));
  assign out_free = !out_valid_q || out_ready_i;

  pts_match u_match (
    .entry_i    (rdata_q),
    .pid_i      (pid_q),
    .pid_any_i  (pid_any_q),
    .kind_i     (kind_q),
    .kind_any_i (kind_any_q),
    .match_o    (match)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = quick ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (!more && !chk_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    keep_d    = keep_q;
    rm_d      = rm_q;
    found_d   = found_q;
    chk_d     = 1'b0;
    status_d  = status_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = keep_q[IW-1:0];
    mem_wdata = rdata_q;
    item_ld   = 1'b0;
    out_ld    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_ld  = 1'b1;
          rd_idx_d = '0;
          keep_d   = '0;
          rm_d     = '0;
          found_d  = 1'b0;
          status_d = ST_OK;
          if (func_i == FUNC_REMOVE) begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
            end else if (pid_any_i && kind_any_i) begin
              rm_d  = cnt_q;
              cnt_d = '0;
            end
          end
        end
      end
      S_SCAN: begin
        if (more) begin
          mem_re   = 1'b1;
          rd_idx_d = rd_idx_q + CW'(1);
          chk_d    = 1'b1;
        end
        if (chk_q) begin
          if (func_q == FUNC_ADD) begin
            if (match.same) begin
              found_d = 1'b1;
            end
          end else if (match.hit) begin
            rm_d = rm_q + CW'(1);
          end else begin
            // keep index never passes the read index, so no hazard
            mem_we = 1'b1;
            keep_d = keep_q + CW'(1);
          end
        end
        if (!more && !chk_q) begin
          if (func_q == FUNC_ADD) begin
            if (!found_q) begin
              if (cnt_q == CW'(MAX_ENTRIES)) begin
                status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_q[IW-1:0];
                mem_wdata = item_word;
                cnt_d     = cnt_q + CW'(1);
              end
            end
          end else begin
            cnt_d = keep_q;
          end
        end
      end
      S_DONE: begin
        out_ld = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      chk_q   <= chk_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    keep_q   <= keep_d;
    rm_q     <= rm_d;
    found_q  <= found_d;
    status_q <= status_d;
    if (item_ld) begin
      func_q     <= func_e'(func_i);
      pid_q      <= pid_i;
      pid_any_q  <= pid_any_i;
      kind_q     <= kind_i;
      kind_any_q <= kind_any_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store_q[rd_idx_q[IW-1:0]];
    end
  end

  // counts leave masked to the field width
  assign cnt_ext = {{OUT_W{1'b0}}, cnt_q};
  assign rm_ext  = {{OUT_W{1'b0}}, rm_q};

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      status_o      <= status_q;
      entries_now_o <= cnt_ext[OUT_W-1:0];
      removed_o     <= rm_ext[OUT_W-1:0];
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[src/pts_check.sv]
module pts_check #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [pts_pkg::STATUS_W-1:0]   status_o,
  input logic [pts_pkg::OUT_W-1:0]      entries_now_o,
  input logic [pts_pkg::OUT_W-1:0]      removed_o
);
  import pts_pkg::*;

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(entries_now_o) && $stable(removed_o))
    else $error("output beat changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_EMPTY) ||
    (status_o == ST_FULL))
    else $error("undefined status code");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (entries_now_o == '0) &&
    (removed_o == '0))
    else $error("empty remove reports entries");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |->
    (entries_now_o == OUT_W'(MAX_ENTRIES)) && (removed_o == '0))
    else $error("full add with wrong count");

endmodule

bind pid_type_set_table pts_check #(.MAX_ENTRIES(MAX_ENTRIES)) u_pts_check (.*);
